// ===== rtl/core/fpcu_pkg.sv =====
// Shared types, codes and constants of the first-person camera update unit.
`default_nettype none
package fpcu_pkg;

  // Fixed-point formats and iteration counts
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_DEPTH   = 24;

  // CORDIC gain preset (Q.30) and angle limits (Q9.16 degrees, Q.24 for CORDIC)
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [28:0] ANG_HALF    = 29'sd11796480;
  localparam logic signed [28:0] ANG_FULL    = 29'sd23592960;
  localparam logic signed [28:0] PITCH_LIM   = 29'sd5832704;
  localparam logic signed [32:0] Z_Q90       = 33'sd1509949440;
  localparam logic signed [32:0] Z_Q180      = 33'sd3019898880;
  localparam logic [16:0]        ONE_Q16     = 17'd65536;

  // Pose after reset
  localparam logic signed [24:0] YAW_RESET   = -25'sd5898240;
  localparam logic signed [17:0] VEC_ONE     = 18'sd65536;
  localparam logic signed [17:0] VEC_MONE    = -18'sd65536;

  // atan(2^-i) in degrees, Q.24
  localparam logic [31:0] ATAN_Q24 [ATAN_DEPTH] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // Configuration register indexes
  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_LOOK_SENS   = 3'd1;
  localparam logic [2:0] CFG_WORLD_UP_X  = 3'd2;
  localparam logic [2:0] CFG_WORLD_UP_Y  = 3'd3;
  localparam logic [2:0] CFG_WORLD_UP_Z  = 3'd4;

  typedef enum logic [1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LOOK  = 2'd1,
    MODE_PLACE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    NRM_FRONT,
    NRM_RIGHT,
    NRM_UP
  } nrm_dst_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MV_MUL,
    ST_MV_VEL,
    ST_MV_PROD,
    ST_MV_ADD,
    ST_LK_MUL,
    ST_LK_YAW,
    ST_PL_YAW,
    ST_WRAP_YAW,
    ST_WRAP_PITCH,
    ST_CS_INIT,
    ST_CS_ITER,
    ST_CS_END,
    ST_FR_MUL,
    ST_FR_MUL2,
    ST_FR_SET,
    ST_NM_SQ,
    ST_NM_ACC,
    ST_SQ_INIT,
    ST_SQ_ITER,
    ST_SQ_END,
    ST_DV_INIT,
    ST_DV_ITER,
    ST_DV_STORE,
    ST_NM_END,
    ST_CX_A,
    ST_CX_B,
    ST_CX_C,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/first_person_camera_update_unit.sv =====
// Top level of the first-person camera update unit: sequencer and shared datapath.
`default_nettype none
// The unit holds a fly-camera pose (position, yaw, pitch, front, right, up y) and
// takes one item at a time; in_ready is high only while it is idle. A look or
// place item runs through one shared 32x32 multiplier, a 16-step CORDIC run for yaw
// and for pitch, and three normalizations, each with a 28-step bit-serial square
// root and an 18-step restoring divider per component; the angle wrap removes one
// 360 degree turn at a time. The result beat sits in an output register, so the
// next item is taken while it waits. Configuration is to be written through
// cfg_wr_en/cfg_index/cfg_wdata while the unit is idle; the user is bound to this,
// as the block itself does not enforce it.
module first_person_camera_update_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write port
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [1:0]         in_move_dir,
  input  wire logic [15:0]        in_frame_time,
  input  wire logic signed [19:0] in_turn_yaw,
  input  wire logic signed [19:0] in_turn_pitch,
  input  wire logic               in_clamp_pitch,
  input  wire logic signed [31:0] in_place_x,
  input  wire logic signed [31:0] in_place_y,
  input  wire logic signed [31:0] in_place_z,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [17:0]      out_front_x,
  output logic signed [17:0]      out_front_y,
  output logic signed [17:0]      out_front_z,
  output logic signed [17:0]      out_right_x,
  output logic signed [17:0]      out_right_z,
  output logic signed [17:0]      out_up_y,
  output logic signed [24:0]      out_yaw,
  output logic signed [24:0]      out_pitch,
  output logic                    out_degenerate
);
  import fpcu_pkg::*;

  // Sequencer
  state_t state_r, state_nxt;

  // Configuration registers
  logic [23:0]        speed_r;
  logic [15:0]        sens_r;
  logic signed [17:0] wu_r [3];

  // Item fields held for the run
  mode_t              mode_r;
  dir_t               dir_r;
  logic [15:0]        dt_r;
  logic signed [19:0] ty_r, tp_r;
  logic               clamp_r;

  // Pose
  logic signed [31:0] pos_r [3];
  logic signed [24:0] yaw_r, pitch_r;
  logic signed [17:0] front_r [3];
  logic signed [17:0] right_r [3];
  logic signed [17:0] up_y_r;
  logic               degen_r;

  // Shared datapath registers
  logic signed [63:0] prod_r;
  logic [30:0]        vel_r;
  logic signed [28:0] ang_r;
  logic [1:0]         k_r;
  logic [4:0]         it_r;
  logic               cs_sel_r;
  logic               neg_r;
  logic signed [32:0] cz_r;
  logic signed [31:0] cx_r, cy_r;
  logic signed [31:0] sy_r, cyaw_r, sp_r, cp_r;
  logic signed [27:0] c_r [3];
  logic [55:0]        n2_r, sqn_r, root_r, bit4_r;
  logic [27:0]        len_r;
  logic [45:0]        rem_r, dvs_r;
  logic [17:0]        q_r;
  logic signed [35:0] acc_r;
  logic signed [17:0] nv_r [3];
  nrm_dst_t           nrm_dst_r;
  logic               cx_sel_r;

  // Result register
  logic               out_valid_r;
  logic signed [31:0] o_pos_r [3];
  logic signed [17:0] o_front_r [3];
  logic signed [17:0] o_right_x_r, o_right_z_r, o_up_y_r;
  logic signed [24:0] o_yaw_r, o_pitch_r;
  logic               o_degen_r;

  // Shared multiplier
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  // Helper nets
  logic               in_beat, out_load;
  logic [1:0]         k1, k2;
  logic signed [17:0] cxa1, cxa2, cxb1, cxb2;
  logic signed [17:0] mv_vec;
  logic [17:0]        mv_mag;
  logic signed [63:0] off_rnd;
  logic signed [27:0] look_off;
  logic signed [28:0] pitch_sum, pitch_src;
  logic               wrap_hi, wrap_lo, wrap_ok;
  logic signed [32:0] z_init, z_fold;
  logic               z_neg;
  logic signed [31:0] dx, dy;
  logic signed [31:0] cs_s, cs_c;
  logic [46:0]        vel_full;
  logic signed [63:0] mv_rnd;
  logic [33:0]        mv_p;
  logic signed [34:0] mv_sum;
  logic signed [31:0] mv_sat;
  logic               mv_neg;
  logic signed [63:0] fr_rnd;
  logic signed [32:0] sp_rnd;
  logic [55:0]        sq_sum;
  logic [27:0]        dv_mag;
  logic [46:0]        dv_diff;
  logic [16:0]        dv_qc;
  logic signed [36:0] cx_diff, cx_rnd;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Cross-product operand indexes: (k+1) mod 3 and (k+2) mod 3
  always_comb begin
    unique case (k_r)
      2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
      2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
      default: begin k1 = 2'd0; k2 = 2'd1; end
    endcase
  end

  assign cxa1 = cx_sel_r ? right_r[k1] : front_r[k1];
  assign cxa2 = cx_sel_r ? right_r[k2] : front_r[k2];
  assign cxb1 = cx_sel_r ? front_r[k1] : wu_r[k1];
  assign cxb2 = cx_sel_r ? front_r[k2] : wu_r[k2];

  // Move step: vector part, magnitude, rounded step and saturated position
  assign mv_vec   = (dir_r == DIR_FWD || dir_r == DIR_BACK) ? front_r[k_r] : right_r[k_r];
  assign mv_mag   = mv_vec[17] ? 18'(-mv_vec) : 18'(mv_vec);
  assign vel_full = {1'b0, prod_r[39:0], 6'd0} + {2'd0, prod_r[39:0], 5'd0} +
                    {5'd0, prod_r[39:0], 2'd0};
  assign mv_rnd   = prod_r + 64'sd32768;
  assign mv_p     = mv_rnd[49:16];
  assign mv_neg   = (dir_r == DIR_BACK || dir_r == DIR_LEFT) ^ mv_vec[17];
  assign mv_sum   = mv_neg ? (35'(pos_r[k_r]) - $signed({1'b0, mv_p}))
                           : (35'(pos_r[k_r]) + $signed({1'b0, mv_p}));
  always_comb begin
    if (mv_sum > 35'sd2147483647) begin
      mv_sat = 32'sh7FFFFFFF;
    end else if (mv_sum < -35'sd2147483648) begin
      mv_sat = 32'sh80000000;
    end else begin
      mv_sat = mv_sum[31:0];
    end
  end

  // Look offset: product of offset and sensitivity rounded to Q.16
  assign off_rnd  = prod_r + 64'sd128;
  assign look_off = off_rnd[35:8];
  assign pitch_sum = 29'(pitch_r) + 29'(look_off);
  always_comb begin
    pitch_src = pitch_sum;
    if (mode_r == MODE_PLACE) begin
      pitch_src = 29'($signed({tp_r, 8'd0}));
    end else if (clamp_r) begin
      if (pitch_sum > PITCH_LIM) begin
        pitch_src = PITCH_LIM;
      end else if (pitch_sum < -PITCH_LIM) begin
        pitch_src = -PITCH_LIM;
      end
    end
  end

  // Angle wrap to [-180,180): one turn per cycle
  assign wrap_hi = (ang_r >= ANG_HALF);
  assign wrap_lo = (ang_r < -ANG_HALF);
  assign wrap_ok = !wrap_hi && !wrap_lo;

  // CORDIC: fold into [-90,90], then rotate
  assign z_init = cs_sel_r ? 33'({pitch_r, 8'd0}) : 33'({yaw_r, 8'd0});
  always_comb begin
    z_fold = z_init;
    z_neg  = 1'b0;
    if (z_init > Z_Q90) begin
      z_fold = z_init - Z_Q180;
      z_neg  = 1'b1;
    end else if (z_init < -Z_Q90) begin
      z_fold = z_init + Z_Q180;
      z_neg  = 1'b1;
    end
  end
  assign dx   = cy_r >>> it_r;
  assign dy   = cx_r >>> it_r;
  assign cs_s = neg_r ? -cy_r : cy_r;
  assign cs_c = neg_r ? -cx_r : cx_r;

  // Front from sines and cosines, rounded to Q.24
  assign fr_rnd = prod_r + 64'sh0000_0008_0000_0000;
  assign sp_rnd = 33'(sp_r) + 33'sd32;

  // Square root, divider and cross-product arithmetic
  assign sq_sum  = root_r + bit4_r;
  assign dv_mag  = c_r[k_r][27] ? 28'(-c_r[k_r]) : 28'(c_r[k_r]);
  assign dv_diff = {1'b0, rem_r} - {1'b0, dvs_r};
  assign dv_qc   = (q_r > 18'(ONE_Q16)) ? ONE_Q16 : q_r[16:0];
  assign cx_diff = 37'(acc_r) - 37'(prod_r[35:0]);
  assign cx_rnd  = cx_diff + 37'sd128;

  // Multiplier operands and next state
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode_t'(in_mode))
            MODE_MOVE:  state_nxt = ST_MV_MUL;
            MODE_LOOK:  state_nxt = ST_LK_MUL;
            MODE_PLACE: state_nxt = ST_PL_YAW;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MV_MUL: begin
        mul_en    = 1'b1;
        mul_a     = 32'({8'd0, speed_r});
        mul_b     = 32'({16'd0, dt_r});
        state_nxt = ST_MV_VEL;
      end
      ST_MV_VEL:  state_nxt = ST_MV_PROD;
      ST_MV_PROD: begin
        mul_en    = 1'b1;
        mul_a     = 32'({14'd0, mv_mag});
        mul_b     = 32'({1'b0, vel_r});
        state_nxt = ST_MV_ADD;
      end
      ST_MV_ADD:  state_nxt = (k_r == 2'd2) ? ST_DONE : ST_MV_PROD;
      ST_LK_MUL: begin
        mul_en    = 1'b1;
        mul_a     = 32'(ty_r);
        mul_b     = 32'({16'd0, sens_r});
        state_nxt = ST_LK_YAW;
      end
      ST_LK_YAW: begin
        mul_en    = 1'b1;
        mul_a     = 32'(tp_r);
        mul_b     = 32'({16'd0, sens_r});
        state_nxt = ST_WRAP_YAW;
      end
      ST_PL_YAW:     state_nxt = ST_WRAP_YAW;
      ST_WRAP_YAW:   state_nxt = wrap_ok ? ST_WRAP_PITCH : ST_WRAP_YAW;
      ST_WRAP_PITCH: state_nxt = wrap_ok ? ST_CS_INIT : ST_WRAP_PITCH;
      ST_CS_INIT:    state_nxt = ST_CS_ITER;
      ST_CS_ITER: begin
        if (it_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_CS_END;
        end
      end
      ST_CS_END: state_nxt = cs_sel_r ? ST_FR_MUL : ST_CS_INIT;
      ST_FR_MUL: begin
        mul_en    = 1'b1;
        mul_a     = cyaw_r;
        mul_b     = cp_r;
        state_nxt = ST_FR_MUL2;
      end
      ST_FR_MUL2: begin
        mul_en    = 1'b1;
        mul_a     = sy_r;
        mul_b     = cp_r;
        state_nxt = ST_FR_SET;
      end
      ST_FR_SET: state_nxt = ST_NM_SQ;
      ST_NM_SQ: begin
        mul_en    = 1'b1;
        mul_a     = 32'(c_r[k_r]);
        mul_b     = 32'(c_r[k_r]);
        state_nxt = ST_NM_ACC;
      end
      ST_NM_ACC:  state_nxt = (k_r == 2'd2) ? ST_SQ_INIT : ST_NM_SQ;
      ST_SQ_INIT: state_nxt = ST_SQ_ITER;
      ST_SQ_ITER: state_nxt = bit4_r[0] ? ST_SQ_END : ST_SQ_ITER;
      ST_SQ_END:  state_nxt = (root_r == '0) ? ST_NM_END : ST_DV_INIT;
      ST_DV_INIT: state_nxt = ST_DV_ITER;
      ST_DV_ITER: state_nxt = (it_r == '0) ? ST_DV_STORE : ST_DV_ITER;
      ST_DV_STORE: state_nxt = (k_r == 2'd2) ? ST_NM_END : ST_DV_INIT;
      ST_NM_END:  state_nxt = (nrm_dst_r == NRM_UP) ? ST_DONE : ST_CX_A;
      ST_CX_A: begin
        mul_en    = 1'b1;
        mul_a     = 32'(cxa1);
        mul_b     = 32'(cxb2);
        state_nxt = ST_CX_B;
      end
      ST_CX_B: begin
        mul_en    = 1'b1;
        mul_a     = 32'(cxa2);
        mul_b     = 32'(cxb1);
        state_nxt = ST_CX_C;
      end
      ST_CX_C: state_nxt = (k_r == 2'd2) ? ST_NM_SQ : ST_CX_A;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration, pose and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= 24'd163840;
      sens_r      <= 16'd6554;
      wu_r[0]     <= '0;
      wu_r[1]     <= VEC_ONE;
      wu_r[2]     <= '0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      yaw_r       <= YAW_RESET;
      pitch_r     <= '0;
      front_r[0]  <= '0;
      front_r[1]  <= '0;
      front_r[2]  <= VEC_MONE;
      right_r[0]  <= VEC_ONE;
      right_r[1]  <= '0;
      right_r[2]  <= '0;
      up_y_r      <= VEC_ONE;
      degen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MOVE_SPEED: speed_r <= cfg_wdata;
          CFG_LOOK_SENS:  sens_r  <= cfg_wdata[15:0];
          CFG_WORLD_UP_X: wu_r[0] <= cfg_wdata[17:0];
          CFG_WORLD_UP_Y: wu_r[1] <= cfg_wdata[17:0];
          CFG_WORLD_UP_Z: wu_r[2] <= cfg_wdata[17:0];
          default: ;
        endcase
      end
      // place sets the position at once
      if (in_beat && mode_t'(in_mode) == MODE_PLACE) begin
        pos_r[0] <= in_place_x;
        pos_r[1] <= in_place_y;
        pos_r[2] <= in_place_z;
      end
      // step the position
      if (state_r == ST_MV_ADD) begin
        pos_r[k_r] <= mv_sat;
      end
      // commit wrapped angles
      if (state_r == ST_WRAP_YAW && wrap_ok) begin
        yaw_r <= ang_r[24:0];
      end
      if (state_r == ST_WRAP_PITCH && wrap_ok) begin
        pitch_r <= ang_r[24:0];
      end
      // commit normalized vectors
      if (state_r == ST_NM_END) begin
        unique case (nrm_dst_r)
          NRM_FRONT: begin
            front_r[0] <= nv_r[0];
            front_r[1] <= nv_r[1];
            front_r[2] <= nv_r[2];
          end
          NRM_RIGHT: begin
            right_r[0] <= nv_r[0];
            right_r[1] <= nv_r[1];
            right_r[2] <= nv_r[2];
            degen_r    <= (len_r == '0);
          end
          default: up_y_r <= nv_r[1];
        endcase
      end
      // result beat
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Shared datapath
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_r  <= mode_t'(in_mode);
          dir_r   <= dir_t'(in_move_dir);
          dt_r    <= in_frame_time;
          ty_r    <= in_turn_yaw;
          tp_r    <= in_turn_pitch;
          clamp_r <= in_clamp_pitch;
        end
      end
      ST_MV_VEL: begin
        vel_r <= vel_full[46:16];
        k_r   <= 2'd0;
      end
      ST_MV_ADD: k_r <= k_r + 2'd1;
      ST_LK_YAW: ang_r <= 29'(yaw_r) + 29'(look_off);
      ST_PL_YAW: ang_r <= 29'($signed({ty_r, 8'd0}));
      ST_WRAP_YAW, ST_WRAP_PITCH: begin
        if (wrap_hi) begin
          ang_r <= ang_r - ANG_FULL;
        end else if (wrap_lo) begin
          ang_r <= ang_r + ANG_FULL;
        end else if (state_r == ST_WRAP_YAW) begin
          ang_r <= pitch_src;
        end else begin
          cs_sel_r <= 1'b0;
        end
      end
      ST_CS_INIT: begin
        cz_r  <= z_fold;
        neg_r <= z_neg;
        cx_r  <= CORDIC_GAIN;
        cy_r  <= '0;
        it_r  <= '0;
      end
      ST_CS_ITER: begin
        if (!cz_r[32]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - 33'({1'b0, ATAN_Q24[it_r]});
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + 33'({1'b0, ATAN_Q24[it_r]});
        end
        it_r <= it_r + 5'd1;
      end
      ST_CS_END: begin
        if (cs_sel_r) begin
          sp_r <= cs_s;
          cp_r <= cs_c;
        end else begin
          sy_r   <= cs_s;
          cyaw_r <= cs_c;
        end
        cs_sel_r <= 1'b1;
      end
      ST_FR_MUL2: c_r[0] <= fr_rnd[63:36];
      ST_FR_SET: begin
        c_r[2]    <= fr_rnd[63:36];
        c_r[1]    <= 28'($signed(sp_rnd[32:6]));
        n2_r      <= '0;
        k_r       <= 2'd0;
        nrm_dst_r <= NRM_FRONT;
      end
      ST_NM_ACC: begin
        n2_r <= n2_r + prod_r[55:0];
        k_r  <= k_r + 2'd1;
      end
      ST_SQ_INIT: begin
        sqn_r  <= n2_r;
        root_r <= '0;
        bit4_r <= 56'd1 << 54;
      end
      ST_SQ_ITER: begin
        if (sqn_r >= sq_sum) begin
          sqn_r  <= sqn_r - sq_sum;
          root_r <= (root_r >> 1) + bit4_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit4_r <= bit4_r >> 2;
      end
      ST_SQ_END: begin
        len_r <= root_r[27:0];
        k_r   <= 2'd0;
        nv_r[0] <= '0;
        nv_r[1] <= '0;
        nv_r[2] <= '0;
      end
      ST_DV_INIT: begin
        rem_r <= {2'd0, dv_mag, 16'd0} + 46'(len_r[27:1]);
        dvs_r <= {1'b0, len_r, 17'd0};
        q_r   <= '0;
        it_r  <= 5'd17;
      end
      ST_DV_ITER: begin
        if (!dv_diff[46]) begin
          rem_r <= dv_diff[45:0];
          q_r   <= {q_r[16:0], 1'b1};
        end else begin
          q_r   <= {q_r[16:0], 1'b0};
        end
        dvs_r <= dvs_r >> 1;
        it_r  <= it_r - 5'd1;
      end
      ST_DV_STORE: begin
        nv_r[k_r] <= c_r[k_r][27] ? -18'({1'b0, dv_qc}) : 18'({1'b0, dv_qc});
        k_r       <= k_r + 2'd1;
      end
      ST_NM_END: begin
        k_r <= 2'd0;
        unique case (nrm_dst_r)
          NRM_FRONT: cx_sel_r <= 1'b0;
          NRM_RIGHT: cx_sel_r <= 1'b1;
          default: ;
        endcase
      end
      ST_CX_B: acc_r <= prod_r[35:0];
      ST_CX_C: begin
        c_r[k_r] <= cx_rnd[35:8];
        if (k_r == 2'd2) begin
          k_r  <= 2'd0;
          n2_r <= '0;
          nrm_dst_r <= (nrm_dst_r == NRM_FRONT) ? NRM_RIGHT : NRM_UP;
        end else begin
          k_r <= k_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Result register: snapshot of the pose
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_pos_r[0]   <= pos_r[0];
      o_pos_r[1]   <= pos_r[1];
      o_pos_r[2]   <= pos_r[2];
      o_front_r[0] <= front_r[0];
      o_front_r[1] <= front_r[1];
      o_front_r[2] <= front_r[2];
      o_right_x_r  <= right_r[0];
      o_right_z_r  <= right_r[2];
      o_up_y_r     <= up_y_r;
      o_yaw_r      <= yaw_r;
      o_pitch_r    <= pitch_r;
      o_degen_r    <= degen_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = o_pos_r[0];
  assign out_pos_y      = o_pos_r[1];
  assign out_pos_z      = o_pos_r[2];
  assign out_front_x    = o_front_r[0];
  assign out_front_y    = o_front_r[1];
  assign out_front_z    = o_front_r[2];
  assign out_right_x    = o_right_x_r;
  assign out_right_z    = o_right_z_r;
  assign out_up_y       = o_up_y_r;
  assign out_yaw        = o_yaw_r;
  assign out_pitch      = o_pitch_r;
  assign out_degenerate = o_degen_r;

endmodule
`default_nettype wire
